@@ rtl/mrfc_pkg.sv @@
`timescale 1ns / 1ps

package mrfc_pkg;

  // Result kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // CRC-16/MODBUS constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] byte_count;
    logic       crc_error;
    logic       last;
  } result_t;

  // One byte of the reflected CRC: eight shift/xor steps on a 16-bit value.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/mrfc_parser.sv @@
`timescale 1ns / 1ps

module mrfc_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  output logic               res_valid,
  output mrfc_pkg::result_t  res
);

  typedef enum logic [2:0] {
    PH_ADDR  = 3'd0,
    PH_FUNC  = 3'd1,
    PH_COUNT = 3'd2,
    PH_DATA  = 3'd3,
    PH_CRC1  = 3'd4,
    PH_CRC2  = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] crc_register, crc_register_next;
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  bytes_seen, bytes_seen_next;
  logic [7:0]  first_crc_byte, first_crc_byte_next;
  logic [15:0] crc_upd;
  logic [7:0]  seen_inc;

  // A frame start always restarts parsing at the address byte.
  phase_t      cur;

  always_comb begin
    cur = frame_start ? PH_ADDR : phase;
    seen_inc = bytes_seen + 8'd1;
    crc_upd = mrfc_pkg::crc_byte((cur == PH_ADDR) ? mrfc_pkg::CRC_INIT : crc_register,
                                 rx_byte);
    phase_next          = phase;
    crc_register_next   = crc_register;
    payload_length_next = payload_length;
    bytes_seen_next     = bytes_seen;
    first_crc_byte_next = first_crc_byte;
    res_valid           = 1'b0;
    res                 = '0;
    res.byte_count      = payload_length;
    unique case (cur)
      PH_FUNC: begin
        crc_register_next = crc_upd;
        phase_next        = PH_COUNT;
      end
      PH_COUNT: begin
        crc_register_next   = crc_upd;
        payload_length_next = rx_byte;
        bytes_seen_next     = 8'd0;
        phase_next          = (rx_byte == 8'd0) ? PH_CRC1 : PH_DATA;
      end
      PH_DATA: begin
        crc_register_next = crc_upd;
        bytes_seen_next   = seen_inc;
        if (seen_inc >= payload_length) begin
          phase_next = PH_CRC1;
        end
        res_valid         = 1'b1;
        res.kind          = mrfc_pkg::KIND_DATA;
        res.payload_byte  = rx_byte;
        res.payload_index = bytes_seen;
      end
      PH_CRC1: begin
        first_crc_byte_next = rx_byte;
        phase_next          = PH_CRC2;
      end
      PH_CRC2: begin
        res_valid     = 1'b1;
        res.kind      = mrfc_pkg::KIND_STATUS;
        res.last      = 1'b1;
        res.crc_error = (first_crc_byte != crc_register[7:0]) ||
                        (rx_byte != crc_register[15:8]);
        phase_next    = PH_ADDR;
      end
      default: begin
        // Address byte, and any code outside the frame sequence.
        crc_register_next   = crc_upd;
        payload_length_next = 8'd0;
        bytes_seen_next     = 8'd0;
        first_crc_byte_next = 8'd0;
        phase_next          = PH_FUNC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ADDR;
      crc_register   <= mrfc_pkg::CRC_INIT;
      payload_length <= 8'd0;
      bytes_seen     <= 8'd0;
      first_crc_byte <= 8'd0;
    end else if (adv) begin
      phase          <= phase_next;
      crc_register   <= crc_register_next;
      payload_length <= payload_length_next;
      bytes_seen     <= bytes_seen_next;
      first_crc_byte <= first_crc_byte_next;
    end
  end

`ifndef SYNTHESIS
  a_reset_addr: assert property (@(posedge clk) rst |=> (phase == PH_ADDR))
    else $error("parser not waiting for address after reset");
  a_start_func: assert property (@(posedge clk) disable iff (rst)
    (adv && frame_start) |=> (phase == PH_FUNC))
    else $error("frame start did not restart parsing");
  a_crc1_crc2: assert property (@(posedge clk) disable iff (rst)
    (adv && !frame_start && phase == PH_CRC1) |=> (phase == PH_CRC2))
    else $error("first CRC byte not followed by second CRC phase");
  a_data_index: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_seen < payload_length))
    else $error("data index beyond byte count");
`endif

endmodule

@@ rtl/mrfc_out_reg.sv @@
`timescale 1ns / 1ps

module mrfc_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               res_valid,
  input  mrfc_pkg::result_t  res,
  input  logic               out_stall,
  output logic               out_valid,
  output mrfc_pkg::result_t  out_res
);

  // adv is only raised when this register is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

endmodule

@@ rtl/modbus_response_frame_checker.sv @@
`timescale 1ns / 1ps
// An accepted item waits in the input register while the parser works on it combinationally;
// its result is then loaded into the result register and offered from there.
// Throughput: one item per cycle while the output is not stalled, with a byte-wide CRC update.
// Results move through one output register; the input register waits only while it is stalled.
// Reset (rst, synchronous, active high) empties both registers and puts the parser
// back to waiting for an address byte with the CRC at 0xFFFF.

module modbus_response_frame_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] payload_byte,
  output logic [7:0] payload_index,
  output logic [7:0] byte_count,
  output logic       crc_error,
  output logic       last
);

  // Input register: holds one accepted item until the parser consumes it.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;

  // The output register is blocked when it holds a result that is not taken.
  logic blocked;
  logic adv;

  logic              res_valid;
  mrfc_pkg::result_t res;
  mrfc_pkg::result_t out_res;

  assign blocked  = out_valid && out_stall;
  assign adv      = s1_valid && !blocked;
  assign in_stall = s1_valid && blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // The payload only loads on acceptance, so it holds while stalled.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte  <= rx_byte;
      s1_start <= frame_start;
    end
  end

  // Frame parser and CRC: all per-item work happens in one pass.
  mrfc_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .rx_byte     (s1_byte),
    .frame_start (s1_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register: decouples the parser from the downstream stall.
  mrfc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign kind          = out_res.kind;
  assign payload_byte  = out_res.payload_byte;
  assign payload_index = out_res.payload_index;
  assign byte_count    = out_res.byte_count;
  assign crc_error     = out_res.crc_error;
  assign last          = out_res.last;

endmodule

@@ bench/mrfc_result_checker.sv @@
`timescale 1ns / 1ps

module mrfc_result_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       kind,
  input  logic [7:0] payload_byte,
  input  logic [7:0] payload_index,
  input  logic [7:0] byte_count,
  input  logic       crc_error,
  input  logic       last,
  output int         errors,
  output int         pending,
  output int         data_results,
  output int         status_results,
  output int         crc_flagged
);

  typedef enum logic [2:0] {
    P_ADDR, P_FUNC, P_COUNT, P_DATA, P_CRC_LO, P_CRC_HI
  } parse_phase_t;

  parse_phase_t          phase = P_ADDR;
  logic [15:0]           crc_acc = mrfc_pkg::CRC_INIT;
  logic [7:0]            frame_len = '0;
  logic [7:0]            data_taken = '0;
  logic [7:0]            crc_lo_rx = '0;
  mrfc_pkg::result_t     want_results[$];

  // Bit-serial form: the feedback bit is the CRC low bit xor the next data bit.
  function automatic logic [15:0] crc16_step(input logic [15:0] r, input logic [7:0] d);
    logic [15:0] v;
    logic        fb;
    v = r;
    for (int k = 0; k < 8; k++) begin
      fb = v[0] ^ d[k];
      v = {1'b0, v[15:1]};
      if (fb) begin
        v = v ^ mrfc_pkg::CRC_POLY;
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b, input logic s);
    parse_phase_t      ph;
    mrfc_pkg::result_t r;
    ph = s ? P_ADDR : phase;
    r = '0;
    case (ph)
      P_FUNC: begin
        crc_acc = crc16_step(crc_acc, b);
        phase = P_COUNT;
      end
      P_COUNT: begin
        crc_acc = crc16_step(crc_acc, b);
        frame_len = b;
        data_taken = '0;
        phase = (b == 8'd0) ? P_CRC_LO : P_DATA;
      end
      P_DATA: begin
        r.kind = mrfc_pkg::KIND_DATA;
        r.payload_byte = b;
        r.payload_index = data_taken;
        r.byte_count = frame_len;
        want_results.push_back(r);
        crc_acc = crc16_step(crc_acc, b);
        data_taken = data_taken + 8'd1;
        if (data_taken >= frame_len) begin
          phase = P_CRC_LO;
        end
      end
      P_CRC_LO: begin
        crc_lo_rx = b;
        phase = P_CRC_HI;
      end
      P_CRC_HI: begin
        r.kind = mrfc_pkg::KIND_STATUS;
        r.byte_count = frame_len;
        r.crc_error = (crc_lo_rx != crc_acc[7:0]) || (b != crc_acc[15:8]);
        r.last = 1'b1;
        want_results.push_back(r);
        phase = P_ADDR;
      end
      default: begin
        // Address byte: any byte taken while waiting opens a frame.
        crc_acc = crc16_step(mrfc_pkg::CRC_INIT, b);
        frame_len = '0;
        data_taken = '0;
        crc_lo_rx = '0;
        phase = P_FUNC;
      end
    endcase
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        parse_rx_byte(rx_byte, frame_start);
      end
      if (out_valid && !out_stall) begin
        if (want_results.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          mrfc_pkg::result_t w;
          w = want_results.pop_front();
          check_field("kind", kind, w.kind);
          check_field("payload_byte", payload_byte, w.payload_byte);
          check_field("payload_index", payload_index, w.payload_index);
          check_field("byte_count", byte_count, w.byte_count);
          check_field("crc_error", crc_error, w.crc_error);
          check_field("last", last, w.last);
          if (w.kind == mrfc_pkg::KIND_STATUS) begin
            status_results++;
            if (w.crc_error) begin
              crc_flagged++;
            end
          end else begin
            data_results++;
          end
        end
      end
    end
    pending <= want_results.size();
  end

endmodule

@@ bench/modbus_response_frame_checker_tb.sv @@
`timescale 1ns / 1ps

module modbus_response_frame_checker_tb;

  // A run with no accepted item for this many cycles is declared hung. The
  // longest legal quiet stretch is the receiver hold-off plus random stalls.
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 150;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = '0;
  logic       frame_start = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] byte_count;
  logic       crc_error;
  logic       last;

  int errors, pending, data_results, status_results, crc_flagged;

  // Idle percentages for the two sides, changed between run phases.
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  // The stimulus asks for a receiver hold-off by bumping holds_asked; the
  // receiver process notices the difference and counts the hold-off itself.
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;

  int items_sent = 0;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  modbus_response_frame_checker DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .rx_byte(rx_byte), .frame_start(frame_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .payload_byte(payload_byte), .payload_index(payload_index),
    .byte_count(byte_count), .crc_error(crc_error), .last(last)
  );

  mrfc_result_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .rx_byte(rx_byte), .frame_start(frame_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .payload_byte(payload_byte), .payload_index(payload_index),
    .byte_count(byte_count), .crc_error(crc_error), .last(last),
    .errors(errors), .pending(pending),
    .data_results(data_results), .status_results(status_results),
    .crc_flagged(crc_flagged)
  );

  // Receiver side. Outside a hold-off the stall is a fresh random draw every
  // cycle, so stalls land on data items and status items alike.
  always @(posedge clk) begin
    if (holds_done != holds_asked) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: any accepted item on either channel resets the quiet count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending);
      $display("modbus_response_frame_checker_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one byte and returns at the edge where it is accepted. The idle
  // gaps before the item are drawn without looking at the stall.
  task automatic push_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    frame_start <= s;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drops valid and waits until every predicted result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Appends the CRC to a frame body (address, function, count, data) and
  // sends it. A bad frame has one CRC bit flipped, which can land in either
  // CRC byte. A positive cut sends only that many leading bytes, leaving the
  // frame unfinished on the line.
  task automatic send_framed(input logic [7:0] body[$], input int cut, input bit bad,
                             input bit mark);
    logic [7:0]  fr[$];
    logic [15:0] c;
    int          stop;
    fr = body;
    c = mrfc_pkg::CRC_INIT;
    foreach (fr[k]) c = mrfc_pkg::crc_byte(c, fr[k]);
    if (bad) begin
      c = c ^ (16'h0001 << $urandom_range(15));
    end
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
    stop = (cut <= 0 || cut > fr.size()) ? fr.size() : cut;
    for (int k = 0; k < stop; k++) begin
      push_byte(fr[k], (k == 0) && mark);
    end
  endtask

  task automatic send_frame(input int n, input int cut, input bit bad, input bit mark);
    logic [7:0] body[$];
    body.push_back(8'($urandom_range(255)));
    body.push_back(8'($urandom_range(255)));
    body.push_back(n[7:0]);
    repeat (n) body.push_back(8'($urandom_range(255)));
    send_framed(body, cut, bad, mark);
  endtask

  // One random piece of traffic. Most of it is well-formed frames with small
  // payloads; the rest is corrupted CRCs, frames cut short and then restarted,
  // and loose bytes with frame_start at random.
  task automatic random_traffic();
    int pick, n;
    pick = $urandom_range(99);
    if ($urandom_range(39) == 0) begin
      n = $urandom_range(9, 255);
    end else if ($urandom_range(9) == 0) begin
      n = 0;
    end else begin
      n = $urandom_range(1, 8);
    end
    if (pick < 70) begin
      send_frame(n, 0, 1'b0, $urandom_range(5) != 0);
    end else if (pick < 82) begin
      send_frame(n, 0, 1'b1, $urandom_range(5) != 0);
    end else if (pick < 92) begin
      send_frame(n, $urandom_range(1, n + 4), 1'b0, $urandom_range(3) != 0);
      send_frame($urandom_range(8), 0, 1'b0, 1'b1);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with both sides running freely.
    // Empty payload whose address byte comes in without frame_start: the
    // parser is waiting, so it takes the byte as an address anyway.
    send_frame(0, 0, 1'b0, 1'b0);
    // Empty payload with a damaged CRC.
    send_frame(0, 0, 1'b1, 1'b1);
    // Extreme byte values in the address, function and data positions, with a good CRC.
    send_framed({8'h00, 8'hFF, 8'h02, 8'hFF, 8'h00}, 0, 1'b0, 1'b1);
    // Frame abandoned in its data, then a new frame marked by frame_start.
    send_frame(3, 4, 1'b0, 1'b1);
    send_frame(1, 0, 1'b0, 1'b1);
    drain();

    // First random phase: sender idles rarely, receiver stalls often. Early on
    // the receiver holds off for a long stretch while frames keep coming, so
    // the block fills up and stalls its input.
    send_gap_pct = 18;
    recv_stall_pct = 64;
    holds_asked++;
    while (items_sent < 200) random_traffic();

    // Second phase: the roles swap. Halfway the sender stops until every
    // outstanding result has come out.
    send_gap_pct = 64;
    recv_stall_pct = 18;
    while (items_sent < 290) random_traffic();
    drain();
    while (items_sent < 380) random_traffic();

    // Third phase: no idling on either side, including one frame with the
    // largest payload so the data index reaches 254, its top value in a frame.
    send_gap_pct = 0;
    recv_stall_pct = 0;
    send_frame(255, 0, 1'b0, 1'b1);
    while (items_sent < 700) random_traffic();

    drain();
    repeat (8) @(posedge clk);

    $display("sent %0d bytes; %0d data items and %0d frames closed (%0d with CRC error)",
             items_sent, data_results, status_results, crc_flagged);
    $display("traffic mixed good, corrupted, truncated and loose bytes under three idle mixes");
    if (errors == 0) begin
      $display("modbus_response_frame_checker_tb OK");
    end else begin
      $display("modbus_response_frame_checker_tb NOT OK");
    end
    $finish;
  end

endmodule
